// ===== hdl/nppim_pkg.sv =====
// Shared constants, state type and channel spread table for the palette mapper.
package nppim_pkg;

    // Default depth of the palette memory.
    localparam int PALETTE_ENTRIES_DEF = 255;

    // Width of a field that holds an entry position or an entry count.
    localparam int IDX_W = 8;

    // Width of one spread color channel.
    localparam int CH_W = 8;

    // Width of one squared channel difference.
    localparam int SQ_W = 2 * CH_W;

    // Width of a full squared RGB distance (three squares summed).
    localparam int DIST_W = SQ_W + 2;

    // Transfer operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MAP   = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Five-bit channel spread over 0..255, as c * 255 / 31 rounded down.
    localparam logic [CH_W-1:0] SPREAD5_TBL [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // Table lookup of the spread value for one five-bit channel.
    function automatic logic [CH_W-1:0] spread5(input logic [4:0] c5);
        return SPREAD5_TBL[c5];
    endfunction

    // Absolute difference of two spread channels.
    function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hdl/nearest_palette_index_mapper.sv =====
// Top level: palette memory, nearest-color search pipeline and output register.
// A palette write takes effect at its transfer edge. A map transfer reads count entries,
// count being palette_count saturated to PALETTE_ENTRIES; they pass the read, difference,
// square and compare stages. A transparent pixel or an empty palette skips the search.
// Throughput: one item at a time, one palette entry read per cycle from the single read port.
// Reset clears the sequencer, output register and palette_count; the palette is undefined.
module nearest_palette_index_mapper
    import nppim_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    // Configuration write port.
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_wdata,

    // Input channel.
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [IDX_W-1:0]    entry_index,
    input  logic [14:0]         entry_color,
    input  logic                pixel_present,
    input  logic [31:0]         pixel_argb,

    // Output channel.
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_W-1:0]    color_index,
    output logic                not_exact
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(PALETTE_ENTRIES);

    // Configuration register.
    logic [IDX_W-1:0] palette_count_reg;

    // Sequencer.
    state_t state_reg;
    state_t state_next;

    // Pixel and search control.
    logic [CH_W-1:0]  pr_reg;
    logic [CH_W-1:0]  pg_reg;
    logic [CH_W-1:0]  pb_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] issue_reg;
    logic             trans_reg;

    // Pipeline stages.
    logic [14:0]      mem_q_reg;
    logic             m_vld_reg;
    logic             m_last_reg;
    logic [CH_W-1:0]  dr_reg;
    logic [CH_W-1:0]  dg_reg;
    logic [CH_W-1:0]  db_reg;
    logic             d_vld_reg;
    logic             d_last_reg;
    logic [SQ_W-1:0]  sq_r_reg;
    logic [SQ_W-1:0]  sq_g_reg;
    logic [SQ_W-1:0]  sq_b_reg;
    logic             q_vld_reg;
    logic             q_last_reg;

    // Running minimum.
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic              have_reg;

    // Output register.
    logic             out_valid_reg;
    logic [IDX_W-1:0] color_index_reg;
    logic             not_exact_reg;

    // Palette memory.
    logic [14:0] palette_mem [PALETTE_ENTRIES];

    // Control decodes.
    logic             in_xfer;
    logic             out_free;
    logic             rd_en;
    logic             load_out;
    logic             mem_we;
    logic             map_trans;
    logic [IDX_W-1:0] cnt_sat;
    logic [DIST_W-1:0] cand_dist;
    logic             better;

    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign map_trans = !pixel_present || (pixel_argb[31] == 1'b0);
    assign cnt_sat   = (palette_count_reg > CNT_MAX) ? CNT_MAX : palette_count_reg;
    assign mem_we    = in_xfer && (operation == OP_WRITE) && (entry_index < CNT_MAX);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (operation == OP_MAP))
                begin
                    if (map_trans || (cnt_sat == '0))
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (q_vld_reg && q_last_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State-driven control outputs.
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            ST_SCAN:
                rd_en = (issue_reg < cnt_reg);
            ST_FINISH:
                load_out = out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            palette_count_reg <= '0;
        else if (cfg_we)
            palette_count_reg <= cfg_wdata;
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            palette_mem[entry_index[ADDR_W-1:0]] <= entry_color;
        if (rd_en)
            mem_q_reg <= palette_mem[issue_reg[ADDR_W-1:0]];
    end

    // Pixel capture at a map transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer && (operation == OP_MAP))
        begin
            pr_reg <= spread5(pixel_argb[23:19]);
            pg_reg <= spread5(pixel_argb[15:11]);
            pb_reg <= spread5(pixel_argb[7:3]);
        end
    end

    // Search control: count, read issue and transparency flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            issue_reg <= '0;
            trans_reg <= 1'b0;
        end
        else if (in_xfer && (operation == OP_MAP))
        begin
            cnt_reg   <= cnt_sat;
            issue_reg <= '0;
            trans_reg <= map_trans;
        end
        else if (rd_en)
        begin
            issue_reg <= issue_reg + IDX_W'(1);
        end
    end

    // Valid and last flags travel down the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg  <= 1'b0;
            m_last_reg <= 1'b0;
            d_vld_reg  <= 1'b0;
            d_last_reg <= 1'b0;
            q_vld_reg  <= 1'b0;
            q_last_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg  <= rd_en;
            m_last_reg <= rd_en && (issue_reg == (cnt_reg - IDX_W'(1)));
            d_vld_reg  <= m_vld_reg;
            d_last_reg <= m_last_reg;
            q_vld_reg  <= d_vld_reg;
            q_last_reg <= d_last_reg;
        end
    end

    // Spread the entry channels and take the channel differences.
    always_ff @(posedge clk)
    begin
        if (m_vld_reg)
        begin
            dr_reg <= absdiff(spread5(mem_q_reg[14:10]), pr_reg);
            dg_reg <= absdiff(spread5(mem_q_reg[9:5]), pg_reg);
            db_reg <= absdiff(spread5(mem_q_reg[4:0]), pb_reg);
        end
    end

    // Square each channel difference.
    always_ff @(posedge clk)
    begin
        if (d_vld_reg)
        begin
            sq_r_reg <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
            sq_g_reg <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
            sq_b_reg <= SQ_W'(db_reg) * SQ_W'(db_reg);
        end
    end

    // Sum the squares and compare against the best so far; the first minimum wins.
    assign cand_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign better = !have_reg || (cand_dist < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_idx_reg   <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
            have_reg      <= 1'b0;
        end
        else if (in_xfer && (operation == OP_MAP))
        begin
            cmp_idx_reg   <= '0;
            best_idx_reg  <= '0;
            best_dist_reg <= '0;
            have_reg      <= 1'b0;
        end
        else if (q_vld_reg)
        begin
            cmp_idx_reg <= cmp_idx_reg + IDX_W'(1);
            if (better)
            begin
                have_reg      <= 1'b1;
                best_dist_reg <= cand_dist;
                best_idx_reg  <= cmp_idx_reg;
            end
        end
    end

    // Output register, which holds a result until its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            color_index_reg <= '0;
            not_exact_reg   <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
            if (trans_reg)
            begin
                color_index_reg <= '0;
                not_exact_reg   <= 1'b0;
            end
            else
            begin
                color_index_reg <= best_idx_reg + IDX_W'(1);
                not_exact_reg   <= !have_reg || (best_dist_reg != '0);
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign color_index = color_index_reg;
    assign not_exact   = not_exact_reg;

    // Reads stay inside the saturated palette range.
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_reg < CNT_MAX))
        else $error("palette read beyond the memory depth");

    // Pipeline data only moves while a search is under way.
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (m_vld_reg || d_vld_reg || q_vld_reg) |-> (state_reg == ST_SCAN))
        else $error("search pipeline active outside a scan");

    // A found best entry lies inside the searched range.
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && have_reg) |-> (best_idx_reg < cnt_reg))
        else $error("best entry outside the searched range");

    // Loading a result always presents it on the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

// ===== sim/tb_nearest_palette_index_mapper.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nearest palette index mapper: directed table, then random phases.
module tb_nearest_palette_index_mapper;
    import nppim_pkg::*;

    localparam int PAL_DEPTH       = PALETTE_ENTRIES_DEF;
    localparam int ITEMS_PER_PHASE = 15;
    localparam int HOLD_CYCLES     = 700;
    localparam int DRAIN_CYCLES    = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int HOLD_AFTER      = 60;
    localparam int RANDOM_COUNT    = -1;

    // One input transfer, one field per port.
    typedef struct packed {
        logic        operation;
        logic [7:0]  entry_index;
        logic [14:0] entry_color;
        logic        pixel_present;
        logic [31:0] pixel_argb;
    } pixel_item_t;

    // One mapped result.
    typedef struct {
        logic [IDX_W-1:0] color_index;
        logic             not_exact;
    } mapped_t;

    typedef enum logic [1:0] {
        ROW_CONFIG,
        ROW_WRITE,
        ROW_MAP
    } row_kind_t;

    // One line of the directed table; typed rows carry their own answer.
    typedef struct {
        row_kind_t   kind;
        logic [7:0]  entry_index;
        logic [14:0] entry_color;
        logic        pixel_present;
        logic [31:0] pixel_argb;
        bit          typed;
        mapped_t     want;
    } stim_row_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SLOW,
        RX_BEAT
    } rx_mode_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    logic             operation;
    logic [IDX_W-1:0] entry_index;
    logic [14:0]      entry_color;
    logic             pixel_present;
    logic [31:0]      pixel_argb;
    logic             out_valid;
    logic             out_ready;
    logic [IDX_W-1:0] color_index;
    logic             not_exact;

    // Shadow copy of the palette and of palette_count.
    logic [14:0] palette_shadow [PAL_DEPTH];
    bit          palette_written [PAL_DEPTH];
    int          shadow_count = 0;

    mapped_t   expected_q[$];
    stim_row_t directed_rows[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        burst_left   = 0;

    nearest_palette_index_mapper uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .entry_index   (entry_index),
        .entry_color   (entry_color),
        .pixel_present (pixel_present),
        .pixel_argb    (pixel_argb),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .color_index   (color_index),
        .not_exact     (not_exact)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH at %0t: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Spread a five-bit channel over 0..255, rounding down.
    function automatic int widen5(input logic [4:0] c5);
        return (int'(c5) * 255) / 31;
    endfunction

    function automatic int channel_sq(input int a, input int b);
        return (a - b) * (a - b);
    endfunction

    // Nearest entry search over the shadow palette.
    function automatic mapped_t nearest_entry(input logic present, input logic [31:0] argb);
        mapped_t     r;
        int          red;
        int          green;
        int          blue;
        int          lim;
        int          best;
        int          best_dist;
        int          cand_dist;
        logic [14:0] e;
        r.color_index = '0;
        r.not_exact   = 1'b0;
        if (!present || argb[31:24] < 8'd128)
        begin
            return r;
        end
        red   = widen5(argb[23:19]);
        green = widen5(argb[15:11]);
        blue  = widen5(argb[7:3]);
        lim   = (shadow_count > PAL_DEPTH) ? PAL_DEPTH : shadow_count;
        best      = 0;
        best_dist = 0;
        for (int i = 0; i < lim; i++)
        begin
            e         = palette_shadow[i];
            cand_dist = channel_sq(widen5(e[14:10]), red) + channel_sq(widen5(e[9:5]), green)
                      + channel_sq(widen5(e[4:0]), blue);
            if (i == 0 || cand_dist < best_dist)
            begin
                best_dist = cand_dist;
                best      = i;
            end
        end
        r.color_index = IDX_W'(best + 1);
        r.not_exact   = (lim == 0 || best_dist != 0);
        return r;
    endfunction

    // Update the shadow palette, or queue the predicted mapping.
    function automatic void track_item(input pixel_item_t it);
        if (it.operation == OP_WRITE)
        begin
            if (it.entry_index < PAL_DEPTH)
            begin
                palette_shadow[it.entry_index]  = it.entry_color;
                palette_written[it.entry_index] = 1'b1;
            end
        end
        else
        begin
            expected_q.insert(expected_q.size(), nearest_entry(it.pixel_present, it.pixel_argb));
        end
    endfunction

    // Offer one item and return at the edge where it is taken.
    task automatic send_item(input pixel_item_t it);
        int gap;
        bit took;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid      <= 1'b1;
        operation     <= it.operation;
        entry_index   <= it.entry_index;
        entry_color   <= it.entry_color;
        pixel_present <= it.pixel_present;
        pixel_argb    <= it.pixel_argb;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Write palette_count once the block has drained.
    task automatic set_palette_count(input int value);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= IDX_W'(value);
        @(posedge clk);
        cfg_we       <= 1'b0;
        shadow_count = value;
    endtask

    // Make sure every entry the search will read has been written.
    task automatic fill_palette(input int count);
        pixel_item_t it;
        int          lim;
        lim = (count > PAL_DEPTH) ? PAL_DEPTH : count;
        for (int i = 0; i < lim; i++)
        begin
            if (!palette_written[i])
            begin
                it.operation     = OP_WRITE;
                it.entry_index   = 8'(i);
                it.entry_color   = 15'($urandom);
                it.pixel_present = 1'($urandom);
                it.pixel_argb    = $urandom;
                send_item(it);
                track_item(it);
            end
        end
    endtask

    // Random item: mostly opaque pixels, many on palette colors, some writes and transparent ones.
    function automatic pixel_item_t random_item();
        pixel_item_t it;
        logic [14:0] e;
        int          pick;
        int          lim;
        it.operation     = OP_MAP;
        it.entry_index   = 8'($urandom_range(0, 255));
        it.entry_color   = 15'($urandom);
        it.pixel_present = 1'b1;
        it.pixel_argb    = $urandom;
        pick = $urandom_range(0, 99);
        lim  = (shadow_count > PAL_DEPTH) ? PAL_DEPTH : shadow_count;
        if (pick < 20)
        begin
            it.operation     = OP_WRITE;
            it.pixel_present = 1'($urandom);
        end
        else if (pick < 30)
        begin
            if ($urandom_range(0, 1) == 0)
                it.pixel_present = 1'b0;
            else
                it.pixel_argb[31:24] = 8'($urandom_range(0, 127));
        end
        else
        begin
            it.pixel_argb[31:24] = 8'($urandom_range(128, 255));
            if (pick < 65 && lim > 0)
            begin
                // Exact palette color with random low bits below the five kept.
                e = palette_shadow[$urandom_range(0, lim - 1)];
                it.pixel_argb[23:0] = {e[14:10], 3'($urandom), e[9:5], 3'($urandom),
                                       e[4:0], 3'($urandom)};
            end
        end
        return it;
    endfunction

    function automatic void add_config(input int value);
        stim_row_t row;
        row             = '{kind: ROW_CONFIG, default: '0};
        row.entry_index = 8'(value);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_write(input logic [7:0] idx, input logic [14:0] col);
        stim_row_t row;
        row             = '{kind: ROW_WRITE, default: '0};
        row.entry_index = idx;
        row.entry_color = col;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_map(input logic present, input logic [31:0] argb,
                                    input bit typed, input int want_index,
                                    input logic want_not_exact);
        stim_row_t row;
        row                  = '{kind: ROW_MAP, default: '0};
        row.pixel_present    = present;
        row.pixel_argb       = argb;
        row.typed            = typed;
        row.want.color_index = IDX_W'(want_index);
        row.want.not_exact   = want_not_exact;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Receiver: changing stall patterns plus one long hold-off.
    initial
    begin : receiver
        rx_mode_t mode;
        int       cycle_no;
        int       hold_left;
        bit       hold_done;
        mode      = RX_FREE;
        cycle_no  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no % 64 == 0)
                mode = rx_mode_t'($urandom_range(0, 3));
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_FREE: out_ready <= 1'b1;
                    RX_COIN: out_ready <= 1'($urandom_range(0, 1));
                    RX_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cycle_no % 3 == 0);
                endcase
            end
        end
    end

    // Result checker: values are stable from the falling edge to the transfer edge.
    always @(negedge clk)
    begin : check_result
        mapped_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing pending, color_index", -1, color_index);
            end
            else
            begin
                want = expected_q.pop_front();
                if (color_index !== want.color_index)
                    report_mismatch("color_index", want.color_index, color_index);
                if (not_exact !== want.not_exact)
                    report_mismatch("not_exact", want.not_exact, not_exact);
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin
        pixel_item_t it;
        stim_row_t   row;
        int          phase_counts [10];
        int          count;
        int          n;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        operation     = OP_WRITE;
        entry_index   = '0;
        entry_color   = '0;
        pixel_present = 1'b0;
        pixel_argb    = '0;
        foreach (palette_shadow[i])
        begin
            palette_shadow[i]  = '0;
            palette_written[i] = 1'b0;
        end
        phase_counts = '{3, 0, 1, 12, 255, 2, 64, 200, RANDOM_COUNT, 254};

        // Empty palette and transparent pixels.
        add_config(0);
        add_map(1'b0, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        add_map(1'b1, 32'h7FFF_FFFF, 1'b1, 0, 1'b0);
        add_map(1'b1, 32'h8000_0000, 1'b1, 1, 1'b1);
        add_map(1'b1, 32'hFFFF_FFFF, 1'b1, 1, 1'b1);
        // Primaries, a duplicate black for the first-minimum rule, the last slot and one past it.
        add_write(8'd0, 15'h0000);
        add_write(8'd1, 15'h7FFF);
        add_write(8'd2, 15'h7C00);
        add_write(8'd3, 15'h03E0);
        add_write(8'd4, 15'h001F);
        add_write(8'd5, 15'h0000);
        add_write(8'd255, 15'h7FFF);
        add_write(8'd254, 15'h1234);
        add_config(6);
        add_map(1'b1, 32'hFF00_0000, 1'b1, 1, 1'b0);
        add_map(1'b1, 32'hFFFF_FFFF, 1'b1, 2, 1'b0);
        add_map(1'b1, 32'h80FF_0000, 1'b1, 3, 1'b0);
        add_map(1'b1, 32'hFF00_FF00, 1'b1, 4, 1'b0);
        add_map(1'b1, 32'hFF00_00FF, 1'b1, 5, 1'b0);
        // Low three bits of each channel are dropped before the search.
        add_map(1'b1, 32'hFF07_0707, 1'b1, 1, 1'b0);
        add_map(1'b1, 32'hFF80_8080, 1'b0, 0, 1'b0);
        add_map(1'b1, 32'hC312_3456, 1'b0, 0, 1'b0);
        add_map(1'b0, 32'h0000_0000, 1'b1, 0, 1'b0);
        add_config(1);
        add_map(1'b1, 32'hFFFF_FFFF, 1'b1, 1, 1'b1);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CONFIG)
            begin
                set_palette_count(row.entry_index);
            end
            else
            begin
                it.operation     = (row.kind == ROW_WRITE) ? OP_WRITE : OP_MAP;
                it.entry_index   = (row.kind == ROW_WRITE) ? row.entry_index : 8'($urandom);
                it.entry_color   = (row.kind == ROW_WRITE) ? row.entry_color : 15'($urandom);
                it.pixel_present = (row.kind == ROW_WRITE) ? 1'($urandom) : row.pixel_present;
                it.pixel_argb    = (row.kind == ROW_WRITE) ? $urandom : row.pixel_argb;
                send_item(it);
                if (row.kind == ROW_MAP && row.typed)
                    expected_q.insert(expected_q.size(), row.want);
                else
                    track_item(it);
            end
        end

        // Random phases, each under its own palette_count.
        foreach (phase_counts[p])
        begin
            count = (phase_counts[p] == RANDOM_COUNT) ? $urandom_range(0, 255) : phase_counts[p];
            set_palette_count(count);
            fill_palette(count);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                it = random_item();
                send_item(it);
                track_item(it);
            end
        end
        in_valid <= 1'b0;

        // Drain, then watch for stray results.
        for (n = 0; n < 60000 && expected_q.size() != 0; n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch("results still pending at end, count", 0, expected_q.size());

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
